// ===== hdl/meu_pkg.sv =====
`timescale 1ns / 1ps
package meu_pkg;

  localparam int SampleWidth = 24;
  localparam int Channels    = 6;
  localparam int CfgWidth    = 12;
  localparam int IdxWidth    = 3;
  localparam int LongStep    = 480;
  localparam int ShortStep   = 144;

  typedef logic signed [SampleWidth-1:0] sample_t;
  // one bit of headroom for products and sums before saturation
  typedef logic signed [SampleWidth:0]   wide_t;

  localparam wide_t GainM6 = 25'sd4202693;
  localparam wide_t GainM3 = 25'sd5939134;
  localparam wide_t GainM1 = 25'sd7474250;

  typedef struct packed {
    sample_t sample_ch0;
    sample_t sample_ch1;
    sample_t sample_ch2;
    sample_t sample_ch3;
    sample_t sample_ch4;
    sample_t sample_ch5;
  } in_frame_t;

  typedef struct packed {
    sample_t out_ch0;
    sample_t out_ch1;
    sample_t out_ch2;
    sample_t out_ch3;
    sample_t out_ch4;
    sample_t out_ch5;
  } out_frame_t;

  typedef enum logic [IdxWidth-1:0] {
    REG_BLOCK_ENABLE  = 3'd0,
    REG_UPMIX_MODE    = 3'd1,
    REG_MUTE_INPUT    = 3'd2,
    REG_DELAY_ENABLE  = 3'd3,
    REG_SWITCH        = 3'd4
  } reg_index_t;

  // Q1.23 gain, round half up
  function automatic wide_t gain_mul(input wide_t x, input wide_t g);
    logic signed [2*SampleWidth+1:0] p;
    p = (2*SampleWidth+2)'(x) * (2*SampleWidth+2)'(g);
    p = p + ((2*SampleWidth+2)'(1) <<< 22);
    return p[SampleWidth+23:23];
  endfunction

  function automatic sample_t sat_add(input wide_t a, input wide_t b);
    logic signed [SampleWidth+1:0] s;
    logic signed [SampleWidth+1:0] hi;
    logic signed [SampleWidth+1:0] lo;
    s  = (SampleWidth+2)'(a) + (SampleWidth+2)'(b);
    hi = (SampleWidth+2)'(2**(SampleWidth-1) - 1);
    lo = -hi - (SampleWidth+2)'(1);
    if (s > hi) return hi[SampleWidth-1:0];
    if (s < lo) return lo[SampleWidth-1:0];
    return s[SampleWidth-1:0];
  endfunction

endpackage

// ===== hdl/multichannel_echo_upmix_core.sv =====
`timescale 1ns / 1ps
// channel   handshake          payload
// in        in_valid/in_ready  in_data   six input samples
// out       out_valid/out_ready out_data six output samples
// cfg       cfg_we             cfg_index, cfg_data
//
// One frame per cycle, while the output is not stalled, through four register
// stages (read stage, two multiply stages, output register). Each channel owns
// one long and one short delay memory with at most one write and one read per
// frame.
// Reset and a switch write restart write positions and fill counts; entries
// beyond the fill count read as zero, so no clearing pass is needed.
// A stalled output holds its frame while empty stages still take requests.
module multichannel_echo_upmix_core #(
  parameter int DELAY_DEPTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  meu_pkg::in_frame_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output meu_pkg::out_frame_t           out_data,
  input  logic                          cfg_we,
  input  logic [meu_pkg::IdxWidth-1:0]  cfg_index,
  input  logic [meu_pkg::CfgWidth-1:0]  cfg_data
);
  import meu_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int W  = SampleWidth;
  localparam int CH = Channels;

  logic              block_enable, upmix_mode, mute_input, delay_enable;
  logic [2*CH-1:0]   switch_positions;
  logic              clear;

  logic [AW-1:0]     wp  [CH];
  logic [AW:0]       cnt [CH];

  sample_t           smp_in [CH];
  logic              proc0  [CH];
  sample_t           src0   [CH];
  logic [AW-1:0]     laddr  [CH];
  logic [AW-1:0]     saddr  [CH];
  logic              lzero0 [CH];

  logic              v1, v2, v3;
  logic              ready1, ready2, ready3, adv_o;
  logic              accept, move1, move2, move3;

  sample_t           pass1 [CH], pass2 [CH], pass3 [CH];
  logic              proc1 [CH], proc2 [CH], proc3 [CH];
  sample_t           src1  [CH];
  logic              lzero1 [CH], lval1 [CH], sval1 [CH];
  logic [AW-1:0]     wp1 [CH], wp2 [CH];
  sample_t           lrd [CH], srd [CH];
  wide_t             main2 [CH], e2 [CH], d2raw [CH];
  sample_t           first3 [CH];
  wide_t             p3 [CH];
  sample_t           res [CH];

  assign smp_in[0] = in_data.sample_ch0;
  assign smp_in[1] = in_data.sample_ch1;
  assign smp_in[2] = in_data.sample_ch2;
  assign smp_in[3] = in_data.sample_ch3;
  assign smp_in[4] = in_data.sample_ch4;
  assign smp_in[5] = in_data.sample_ch5;

  assign clear = cfg_we && (cfg_index == REG_SWITCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_enable     <= 1'b0;
      upmix_mode       <= 1'b0;
      mute_input       <= 1'b0;
      delay_enable     <= 1'b0;
      switch_positions <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_ENABLE: block_enable     <= cfg_data[0];
        REG_UPMIX_MODE:   upmix_mode       <= cfg_data[0];
        REG_MUTE_INPUT:   mute_input       <= cfg_data[0];
        REG_DELAY_ENABLE: delay_enable     <= cfg_data[0];
        REG_SWITCH:       switch_positions <= cfg_data[2*CH-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign adv_o  = !out_valid || out_ready;
  assign ready3 = !v3 || adv_o;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign in_ready = ready1;
  assign accept = in_valid && ready1;
  assign move1  = v1 && ready2;
  assign move2  = v2 && ready3;
  assign move3  = v3 && adv_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= accept;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (adv_o)  out_valid <= v3;
    end
  end

  for (genvar k = 0; k < CH; k++) begin : g_ch
    logic [W-1:0] lmem [DELAY_DEPTH];
    logic [W-1:0] smem [DELAY_DEPTH];
    logic         lwe, swe;

    always_comb begin
      int            n;
      int            dl;
      int            ds;
      logic [AW-1:0] dla;
      logic [AW-1:0] dsa;
      n  = int'(switch_positions[2*k +: 2]);
      dl = n * LongStep;
      if (dl > DELAY_DEPTH - 1) dl = DELAY_DEPTH - 1;
      ds = (n + 1) * ShortStep;
      if (ds > DELAY_DEPTH - 1) ds = DELAY_DEPTH - 1;
      dla = AW'(dl);
      dsa = AW'(ds);
      lzero0[k] = (dl == 0);
      if (wp[k] >= dla) laddr[k] = wp[k] - dla;
      else laddr[k] = AW'((AW+1)'(wp[k]) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(dla));
      if (wp[k] >= dsa) saddr[k] = wp[k] - dsa;
      else saddr[k] = AW'((AW+1)'(wp[k]) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(dsa));
      proc0[k] = block_enable && ((k < 2) || upmix_mode);
      src0[k]  = mute_input ? '0 : smp_in[k % 2];
    end

    assign lwe = accept && proc0[k] && delay_enable;
    assign swe = move2 && proc2[k] && delay_enable;

    always_ff @(posedge clk) begin
      if (lwe) lmem[wp[k]] <= src0[k];
      if (accept) lrd[k] <= lmem[laddr[k]];
    end

    always_ff @(posedge clk) begin
      if (swe) smem[wp2[k]] <= e2[k][W-1:0];
      if (accept) srd[k] <= smem[saddr[k]];
    end

    // write position and fill count advance together for both lines
    always_ff @(posedge clk) begin
      if (rst || clear) begin
        wp[k]  <= '0;
        cnt[k] <= '0;
      end else if (lwe) begin
        wp[k] <= (wp[k] == AW'(DELAY_DEPTH - 1)) ? '0 : wp[k] + AW'(1);
        if (cnt[k] != (AW+1)'(DELAY_DEPTH)) cnt[k] <= cnt[k] + (AW+1)'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        pass1[k]  <= smp_in[k];
        proc1[k]  <= proc0[k];
        src1[k]   <= src0[k];
        lzero1[k] <= lzero0[k];
        lval1[k]  <= (AW+1)'(laddr[k]) < cnt[k];
        sval1[k]  <= (AW+1)'(saddr[k]) < cnt[k];
        wp1[k]    <= wp[k];
      end
    end

    always_ff @(posedge clk) begin
      wide_t d1;
      if (move1) begin
        if (!delay_enable || lzero1[k]) d1 = wide_t'(src1[k]);
        else if (lval1[k]) d1 = wide_t'(lrd[k]);
        else d1 = '0;
        pass2[k]  <= pass1[k];
        proc2[k]  <= proc1[k];
        wp2[k]    <= wp1[k];
        main2[k]  <= gain_mul(wide_t'(src1[k]), GainM6);
        e2[k]     <= gain_mul(d1, GainM3);
        d2raw[k]  <= sval1[k] ? wide_t'(srd[k]) : '0;
      end
    end

    always_ff @(posedge clk) begin
      if (move2) begin
        pass3[k]  <= pass2[k];
        proc3[k]  <= proc2[k];
        first3[k] <= sat_add(main2[k], e2[k]);
        p3[k]     <= gain_mul(delay_enable ? d2raw[k] : e2[k], GainM1);
      end
    end

    always_ff @(posedge clk) begin
      if (move3) res[k] <= proc3[k] ? sat_add(wide_t'(first3[k]), p3[k]) : pass3[k];
    end
  end

  assign out_data.out_ch0 = res[0];
  assign out_data.out_ch1 = res[1];
  assign out_data.out_ch2 = res[2];
  assign out_data.out_ch3 = res[3];
  assign out_data.out_ch4 = res[4];
  assign out_data.out_ch5 = res[5];

endmodule
